/* rtl/core/bankers_safety_allocator_macros.svh */
// Assertion macros shared by the allocator RTL.
// Depends on nothing; include after the module header.
`ifndef BANKERS_SAFETY_ALLOCATOR_MACROS_SVH
`define BANKERS_SAFETY_ALLOCATOR_MACROS_SVH
// Implication checked each clock, disabled in reset.
`define BSA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled in reset.
`define BSA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* rtl/core/bsa_pkg.sv */
// Shared types and codes for the allocator.
// No dependencies.
`default_nettype none
package bsa_pkg;
    localparam logic [2:0] ACT_SET_AVAIL = 3'd0;
    localparam logic [2:0] ACT_SET_MAX   = 3'd1;
    localparam logic [2:0] ACT_SET_HELD  = 3'd2;
    localparam logic [2:0] ACT_REQUEST   = 3'd3;
    localparam logic [2:0] ACT_RELEASE   = 3'd4;

    localparam logic [2:0] OUT_LOADED   = 3'd0;
    localparam logic [2:0] OUT_GRANTED  = 3'd1;
    localparam logic [2:0] OUT_QUEUED   = 3'd2;
    localparam logic [2:0] OUT_DROPPED  = 3'd3;
    localparam logic [2:0] OUT_RELEASED = 3'd4;
endpackage
`default_nettype wire

/* rtl/core/bsa_lane.sv */
// One lane of the safety walk: tests whether one process can finish.
// Depends on nothing but its ports.
`default_nettype none
module bsa_lane #(
    parameter int NUM_RES = 4,
    parameter int UW      = 8
) (
    input  wire logic [NUM_RES*UW-1:0] i_max,
    input  wire logic [NUM_RES*UW-1:0] i_held,
    input  wire logic [NUM_RES*UW-1:0] i_work,
    input  wire logic                  i_done,
    output logic                       o_can
);
    // A process can finish when every need fits the current work vector.
    always_comb begin
        o_can = !i_done;
        for (int j = 0; j < NUM_RES; j++) begin
            if ({1'b0, i_max[j*UW +: UW]} > {1'b0, i_work[j*UW +: UW]} +
                {1'b0, i_held[j*UW +: UW]}) begin
                o_can = 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/core/bsa_merge.sv */
// Merging stage: picks the lowest finishing lane and adds its holdings to work.
// Depends on nothing but its ports.
`default_nettype none
module bsa_merge #(
    parameter int NUM_PROCS = 8,
    parameter int NUM_RES   = 4,
    parameter int UW        = 8
) (
    input  wire logic [NUM_PROCS-1:0]              i_can,
    input  wire logic [NUM_PROCS*NUM_RES*UW-1:0]   i_held,
    input  wire logic [NUM_RES*UW-1:0]             i_work,
    output logic [NUM_PROCS-1:0]                   o_pick,
    output logic [NUM_RES*UW-1:0]                  o_work
);
    logic [NUM_RES*UW-1:0] w_sel;
    logic [UW:0]           w_sum;

    // One process is folded in per cycle; order does not change the result.
    always_comb begin
        o_pick = '0;
        w_sel  = '0;
        for (int i = NUM_PROCS - 1; i >= 0; i--) begin
            if (i_can[i]) begin
                o_pick = '0;
                o_pick[i] = 1'b1;
                w_sel = i_held[i*NUM_RES*UW +: NUM_RES*UW];
            end
        end
        for (int j = 0; j < NUM_RES; j++) begin
            w_sum = {1'b0, i_work[j*UW +: UW]} + {1'b0, w_sel[j*UW +: UW]};
            o_work[j*UW +: UW] = w_sum[UW] ? {UW{1'b1}} : w_sum[UW-1:0];
        end
    end
endmodule
`default_nettype wire

/* rtl/core/bankers_safety_allocator.sv */
// Banker's algorithm allocator with a lane-parallel safety walk.
// Loads and ignored items go straight to the output state; a request runs the precheck and a
// safety walk that folds in one finished process per cycle; a release updates the tables and
// then runs that check for each queued entry it retries.
// One item at a time: input is accepted in idle once the result register is free or draining.
// Reset (synchronous, active low) clears tables, available totals and queue count.
`default_nettype none
module bankers_safety_allocator #(
    parameter int NUM_PROCS   = 8,
    parameter int NUM_RES     = 4,
    parameter int QUEUE_DEPTH = 8,
    parameter int UNIT_WIDTH  = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // action[2:0], process[5:3], resource[7:6], value[15:8], amount0..3[47:16]
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // avail0..3[31:0], outcome[34:32], retried_grants[38:35], zero fill
    output logic [39:0]      m_axis_tdata
);
    localparam int UW  = UNIT_WIDTH;
    localparam int RW  = NUM_RES * UW;
    localparam int PW  = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam int RIW = (NUM_RES > 1) ? $clog2(NUM_RES) : 1;
    localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam logic [NUM_PROCS-1:0] ALL_DONE = {NUM_PROCS{1'b1}};

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_WALK  = 6'b000100,
        ST_FETCH = 6'b001000,
        ST_QNEXT = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

    t_state r_state;
    logic [NUM_PROCS*RW-1:0] r_max, r_held;
    logic [RW-1:0]           r_avail, r_work, r_amt;
    logic [PW-1:0]           r_proc;
    logic                    r_retry;
    logic [NUM_PROCS-1:0]    r_done;
    logic [CW-1:0]           r_count, r_k, r_kept;
    logic [3:0]              r_retried;
    logic [2:0]              r_outcome;
    logic [PW-1:0]           r_qproc [QUEUE_DEPTH];
    logic [RW-1:0]           r_qamt  [QUEUE_DEPTH];
    logic                    r_ovalid;
    logic [39:0]             r_odata;

    // Input field split.
    logic [2:0] w_act;
    logic [2:0] w_p3;
    logic [1:0] w_r2;
    logic [UW-1:0] w_val;
    logic [RW-1:0] w_amt;
    logic w_pv, w_rv;
    logic [PW-1:0]  w_p;
    logic [RIW-1:0] w_r;
    assign w_act = s_axis_tdata[2:0];
    assign w_p3  = s_axis_tdata[5:3];
    assign w_r2  = s_axis_tdata[7:6];
    assign w_val = UW'(s_axis_tdata[15:8]);
    always_comb begin
        w_amt = '0;
        for (int j = 0; j < NUM_RES; j++) w_amt[j*UW +: UW] = UW'(s_axis_tdata[16+8*j +: 8]);
    end
    assign w_pv = 32'(w_p3) < NUM_PROCS;
    assign w_rv = 32'(w_r2) < NUM_RES;
    assign w_p  = PW'(w_p3);
    assign w_r  = RIW'(w_r2);

    // Tentative holdings with the candidate grant added.
    logic [NUM_PROCS*RW-1:0] w_held_t;
    logic [NUM_PROCS-1:0]    w_can, w_pick;
    logic [RW-1:0]           w_work_n;
    always_comb begin
        w_held_t = r_held;
        for (int j = 0; j < NUM_RES; j++)
            w_held_t[32'(r_proc)*RW + j*UW +: UW] = r_held[32'(r_proc)*RW + j*UW +: UW]
                                                    + r_amt[j*UW +: UW];
    end

    // Lanes, one per process.
    for (genvar i = 0; i < NUM_PROCS; i++) begin : g_lane
        bsa_lane #(.NUM_RES(NUM_RES), .UW(UW)) u_lane (
            .i_max (r_max[i*RW +: RW]),
            .i_held(w_held_t[i*RW +: RW]),
            .i_work(r_work),
            .i_done(r_done[i]),
            .o_can (w_can[i])
        );
    end

    bsa_merge #(.NUM_PROCS(NUM_PROCS), .NUM_RES(NUM_RES), .UW(UW)) u_merge (
        .i_can (w_can),
        .i_held(w_held_t),
        .i_work(r_work),
        .o_pick(w_pick),
        .o_work(w_work_n)
    );

    // Precheck of the request against need and available.
    logic w_pre_ok;
    always_comb begin
        w_pre_ok = 1'b1;
        for (int j = 0; j < NUM_RES; j++) begin
            if ({1'b0, r_amt[j*UW +: UW]} + {1'b0, r_held[32'(r_proc)*RW + j*UW +: UW]} >
                {1'b0, r_max[32'(r_proc)*RW + j*UW +: UW]} ||
                r_amt[j*UW +: UW] > r_avail[j*UW +: UW]) w_pre_ok = 1'b0;
        end
    end

    logic [QW-1:0] w_kidx;
    assign w_kidx = QW'(r_k);

    assign s_axis_tready = (r_state == ST_IDLE) && (!r_ovalid || m_axis_tready);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // Available total after a held load, clamped to the unit range.
    logic [UW:0]   w_hsum;
    logic [UW-1:0] w_held_avail;
    always_comb begin
        w_hsum = {1'b0, r_avail[32'(w_r)*UW +: UW]} +
                 {1'b0, r_held[32'(w_p)*RW + 32'(w_r)*UW +: UW]};
        if (w_hsum < {1'b0, w_val}) w_held_avail = '0;
        else if ((w_hsum - {1'b0, w_val}) > (UW+1)'({UW{1'b1}})) w_held_avail = {UW{1'b1}};
        else w_held_avail = UW'(w_hsum - {1'b0, w_val});
    end

    // Holdings and available totals after a release, clamped to what is held.
    logic [UW-1:0] w_rel;
    logic [UW:0]   w_rsum;
    logic [RW-1:0] w_rel_held, w_rel_avail;
    always_comb begin
        w_rel = '0;
        w_rsum = '0;
        w_rel_held = '0;
        w_rel_avail = '0;
        for (int j = 0; j < NUM_RES; j++) begin
            w_rel = (w_amt[j*UW +: UW] < r_held[32'(w_p)*RW + j*UW +: UW])
                ? w_amt[j*UW +: UW] : r_held[32'(w_p)*RW + j*UW +: UW];
            w_rel_held[j*UW +: UW] = r_held[32'(w_p)*RW + j*UW +: UW] - w_rel;
            w_rsum = {1'b0, r_avail[j*UW +: UW]} + {1'b0, w_rel};
            w_rel_avail[j*UW +: UW] = w_rsum[UW] ? {UW{1'b1}} : w_rsum[UW-1:0];
        end
    end

    // Outcome and next state of an accepted item before any walk.
    logic [2:0] w_first_out;
    t_state     w_first_state;
    logic       w_is_retry;
    assign w_first_out = (w_act == bsa_pkg::ACT_REQUEST) ? bsa_pkg::OUT_DROPPED :
                         (w_act == bsa_pkg::ACT_RELEASE) ? bsa_pkg::OUT_RELEASED :
                         bsa_pkg::OUT_LOADED;
    assign w_is_retry = (w_act == bsa_pkg::ACT_RELEASE) && w_pv;
    assign w_first_state = ((w_act == bsa_pkg::ACT_REQUEST) && w_pv) ? ST_CHECK :
                           w_is_retry ? ST_FETCH : ST_OUT;

    logic [31:0] w_avail_o;

    // Main sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_max <= '0;
            r_held <= '0;
            r_avail <= '0;
            r_count <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == ST_OUT && (!r_ovalid || m_axis_tready)) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_outcome <= w_first_out;
                        r_retried <= '0;
                        r_proc <= w_p;
                        r_amt <= w_amt;
                        r_retry <= w_is_retry;
                        r_k <= '0;
                        r_kept <= '0;
                        r_state <= w_first_state;
                        if (w_act == bsa_pkg::ACT_SET_AVAIL) begin
                            if (w_rv) r_avail[32'(w_r)*UW +: UW] <= w_val;
                        end else if (w_act == bsa_pkg::ACT_SET_MAX) begin
                            if (w_pv && w_rv) r_max[32'(w_p)*RW + 32'(w_r)*UW +: UW] <= w_val;
                        end else if (w_act == bsa_pkg::ACT_SET_HELD) begin
                            if (w_pv && w_rv) begin
                                r_avail[32'(w_r)*UW +: UW] <= w_held_avail;
                                r_held[32'(w_p)*RW + 32'(w_r)*UW +: UW] <= w_val;
                            end
                        end else if (w_act == bsa_pkg::ACT_RELEASE) begin
                            if (w_pv) begin
                                r_held[32'(w_p)*RW +: RW] <= w_rel_held;
                                r_avail <= w_rel_avail;
                            end
                        end
                    end
                end
                ST_FETCH: begin
                    if (r_k >= r_count) begin
                        r_count <= r_kept;
                        r_state <= ST_OUT;
                    end else begin
                        r_proc <= r_qproc[w_kidx];
                        r_amt  <= r_qamt[w_kidx];
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    r_done <= '0;
                    for (int j = 0; j < NUM_RES; j++)
                        r_work[j*UW +: UW] <= r_avail[j*UW +: UW] - r_amt[j*UW +: UW];
                    r_state <= w_pre_ok ? ST_WALK : ST_QNEXT;
                end
                ST_WALK: begin
                    if (r_done == ALL_DONE) begin
                        // Safe: commit the grant.
                        for (int j = 0; j < NUM_RES; j++)
                            r_avail[j*UW +: UW] <= r_avail[j*UW +: UW] - r_amt[j*UW +: UW];
                        r_held <= w_held_t;
                        r_done <= ALL_DONE;
                        r_state <= ST_QNEXT;
                    end else if (w_can == '0) begin
                        r_done <= '0;
                        r_state <= ST_QNEXT;
                    end else begin
                        r_done <= r_done | w_pick;
                        r_work <= w_work_n;
                    end
                end
                ST_QNEXT: begin
                    if (r_retry) begin
                        if (r_done == ALL_DONE) begin
                            if (r_retried != 4'hF) r_retried <= r_retried + 4'd1;
                        end else begin
                            r_qproc[QW'(r_kept)] <= r_proc;
                            r_qamt[QW'(r_kept)]  <= r_amt;
                            r_kept <= r_kept + CW'(1);
                        end
                        r_k <= r_k + CW'(1);
                        r_state <= ST_FETCH;
                    end else begin
                        if (r_done == ALL_DONE) r_outcome <= bsa_pkg::OUT_GRANTED;
                        else if (32'(r_count) >= QUEUE_DEPTH) r_outcome <= bsa_pkg::OUT_DROPPED;
                        else begin
                            r_qproc[QW'(r_count)] <= r_proc;
                            r_qamt[QW'(r_count)]  <= r_amt;
                            r_count <= r_count + CW'(1);
                            r_outcome <= bsa_pkg::OUT_QUEUED;
                        end
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_odata <= {1'b0, r_retried, r_outcome, w_avail_o};
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Available vector shown on the output, 8 bits per resource.
    always_comb begin
        w_avail_o = '0;
        for (int j = 0; j < NUM_RES; j++) w_avail_o[j*8 +: 8] = 8'(r_avail[j*UW +: UW]);
    end

    `include "bankers_safety_allocator_macros.svh"
    `BSA_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, s_axis_tready, r_state == ST_IDLE, "busy ready")
    `BSA_ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1, 32'(r_count) <= QUEUE_DEPTH, "queue overflow")
    `BSA_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready,
        r_state != ST_IDLE, "accept did not start work")
endmodule
`default_nettype wire
